// ----- src/mpcs_pkg.sv -----
// ----------------------------------------------------------------------------
// mpcs_pkg
// Types and constants shared by the mouse packet / cursor selection block.
// ----------------------------------------------------------------------------
package mpcs_pkg;

    typedef enum logic [2:0] {
        CMD_UNDO_SEL  = 3'd0,
        CMD_DRAW_SEL  = 3'd1,
        CMD_REFRESH   = 3'd2,
        CMD_PASTE     = 3'd3,
        CMD_ERASE_CUR = 3'd4,
        CMD_DRAW_CUR  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_X      = 2'd1,
        PH_Y      = 2'd2
    } phase_t;

    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;

    localparam logic [7:0] RESET_COLUMNS = 8'd80;
    localparam logic [7:0] RESET_ROWS    = 8'd25;
    localparam logic [7:0] RESET_CURSOR  = 8'd10;

    // header bits
    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_SYNC   = 3;
    localparam int HDR_XSIGN  = 4;
    localparam int HDR_YSIGN  = 5;
    localparam int HDR_XOVF   = 6;
    localparam int HDR_YOVF   = 7;

    // reciprocal scaling for the speed divisor
    localparam int DIV_SHIFT = 17;

    // command slots of one packet, emitted lowest first
    localparam int NUM_STEPS    = 7;
    localparam int ST_UNDO      = 0;
    localparam int ST_DRAW_SEL  = 1;
    localparam int ST_REF_SEL   = 2;
    localparam int ST_PASTE     = 3;
    localparam int ST_ERASE     = 4;
    localparam int ST_DRAW_CUR  = 5;
    localparam int ST_REFRESH   = 6;

    typedef struct packed {
        logic              left;
        logic              right;
        logic signed [9:0] dx;
        logic signed [9:0] dy;
    } packet_t;

    typedef struct packed {
        logic [7:0] row_start;
        logic [7:0] col_start;
        logic [7:0] row_end;
        logic [7:0] col_end;
    } rect_t;

    typedef struct packed {
        logic       full;
        logic       valid;
    } fifo_status_t;

    function automatic rect_t order_rect(input logic [7:0] a_row, input logic [7:0] a_col,
                                         input logic [7:0] e_row, input logic [7:0] e_col);
        rect_t r;
        if ((e_row < a_row) || ((e_row == a_row) && (e_col < a_col))) begin
            r = '{row_start: e_row, col_start: e_col, row_end: a_row, col_end: a_col};
        end else begin
            r = '{row_start: a_row, col_start: a_col, row_end: e_row, col_end: e_col};
        end
        return r;
    endfunction

endpackage

// ----- src/mpcs_fifo.sv -----
// ----------------------------------------------------------------------------
// mpcs_fifo
// Short register queue between the packet front end and the command sequencer.
// ----------------------------------------------------------------------------
module mpcs_fifo #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  logic [WIDTH-1:0]      push_data,
    input  logic                  pop,
    output logic [WIDTH-1:0]      pop_data,
    output mpcs_pkg::fifo_status_t status
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.valid = (count_reg != '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && status.valid;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/mpcs_front.sv -----
// ----------------------------------------------------------------------------
// mpcs_front
// Byte framing into three-byte packets, sync recovery, overflow filtering and
// scaling of both deltas by the speed divisor.
// ----------------------------------------------------------------------------
module mpcs_front #(
    parameter int SPEED_DIVISOR = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_accept,
    input  logic [7:0]        data_byte,
    input  logic              from_aux,
    output logic              push,
    output mpcs_pkg::packet_t push_pkt
);
    import mpcs_pkg::*;

    localparam int RECIP   = ((2 ** DIV_SHIFT) + SPEED_DIVISOR - 1) / SPEED_DIVISOR;
    localparam int RECIP_W = DIV_SHIFT + 1;
    localparam int MUL_W   = 9 + RECIP_W;

    phase_t     phase_reg, phase_next;
    logic [7:0] header_reg, header_next;
    logic [7:0] x_reg, x_next;

    function automatic logic signed [9:0] scale_delta(input logic [7:0] low, input logic neg);
        logic [8:0]       mag;
        logic [MUL_W-1:0] prod;
        logic [8:0]       q;
        mag  = neg ? (9'd256 - {1'b0, low}) : {1'b0, low};
        prod = MUL_W'(mag) * MUL_W'(RECIP);
        q    = prod[DIV_SHIFT +: 9];
        return neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    always_comb begin
        phase_next  = phase_reg;
        header_next = header_reg;
        x_next      = x_reg;
        if (byte_accept && from_aux) begin
            case (phase_reg)
                PH_X: begin
                    x_next     = data_byte;
                    phase_next = PH_Y;
                end
                PH_Y: begin
                    phase_next = PH_HEADER;
                end
                default: begin
                    phase_next = PH_HEADER;
                    if (data_byte[HDR_SYNC]) begin
                        header_next = data_byte;
                        phase_next  = PH_X;
                    end
                end
            endcase
        end
    end

    always_comb begin
        push = 1'b0;
        if (byte_accept && from_aux && (phase_reg == PH_Y)) begin
            push = !(header_reg[HDR_XOVF] || header_reg[HDR_YOVF]);
        end
    end

    assign push_pkt.left  = header_reg[HDR_LEFT];
    assign push_pkt.right = header_reg[HDR_RIGHT];
    assign push_pkt.dx    = scale_delta(x_reg, header_reg[HDR_XSIGN]);
    assign push_pkt.dy    = scale_delta(data_byte, header_reg[HDR_YSIGN]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            header_reg <= '0;
            x_reg      <= '0;
        end else begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            x_reg      <= x_next;
        end
    end

endmodule

// ----- src/mpcs_back.sv -----
// ----------------------------------------------------------------------------
// mpcs_back
// Command sequencer: applies a packet to selection and cursor state and emits
// its display commands one per cycle, while m_tready allows, through a registered output stage.
// ----------------------------------------------------------------------------
module mpcs_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        screen_columns,
    input  logic [7:0]        screen_rows,
    input  logic              pkt_valid,
    input  mpcs_pkg::packet_t pkt,
    output logic              pkt_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,
    output logic              m_tlast
);
    import mpcs_pkg::*;

    logic                 sel_reg, sel_next;
    logic                 rheld_reg, rheld_next;
    logic [7:0]           cur_col_reg, cur_col_next;
    logic [7:0]           cur_row_reg, cur_row_next;
    logic [7:0]           anc_col_reg, anc_col_next;
    logic [7:0]           anc_row_reg, anc_row_next;
    logic [7:0]           end_col_reg, end_col_next;
    logic [7:0]           end_row_reg, end_row_next;
    logic [NUM_STEPS-1:0] mask_reg, mask_next, mask_new, low_bit, mask_left;
    rect_t                undo_rect_reg, undo_rect_next;
    rect_t                draw_rect_reg, draw_rect_next;
    logic [7:0]           old_col_reg, old_row_reg;
    logic [7:0]           new_col_reg, new_row_reg;

    logic                 out_valid_reg, out_valid_next;
    cmd_t                 out_cmd_reg, out_cmd;
    rect_t                out_rect_reg, out_rect;
    logic                 out_last_reg;

    logic                 out_free, emit;
    logic signed [10:0]   nc, nr;

    assign out_free  = !out_valid_reg || m_tready;
    assign emit      = (mask_reg != '0) && out_free;
    assign low_bit   = mask_reg & (~mask_reg + 1'b1);
    assign mask_left = mask_reg & ~low_bit;
    assign pkt_pop   = pkt_valid && (emit ? (mask_left == '0) : (mask_reg == '0));

    assign nc = $signed({3'b000, cur_col_reg}) + $signed({pkt.dx[9], pkt.dx});
    assign nr = $signed({3'b000, cur_row_reg}) - $signed({pkt.dy[9], pkt.dy});

    // packet entry: state update and command plan
    always_comb begin
        sel_next       = sel_reg;
        rheld_next     = rheld_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        anc_col_next   = anc_col_reg;
        anc_row_next   = anc_row_reg;
        end_col_next   = end_col_reg;
        end_row_next   = end_row_reg;
        undo_rect_next = order_rect(anc_row_reg, anc_col_reg, end_row_reg, end_col_reg);
        draw_rect_next = sel_reg ? order_rect(anc_row_reg, anc_col_reg, cur_row_reg, cur_col_reg)
                                 : order_rect(cur_row_reg, cur_col_reg, cur_row_reg, cur_col_reg);
        mask_new              = '0;
        mask_new[ST_ERASE]    = 1'b1;
        mask_new[ST_DRAW_CUR] = 1'b1;
        mask_new[ST_REFRESH]  = 1'b1;
        if (pkt.left) begin
            mask_new[ST_UNDO]     = sel_reg;
            mask_new[ST_DRAW_SEL] = 1'b1;
            end_col_next          = cur_col_reg;
            end_row_next          = cur_row_reg;
            if (!sel_reg) begin
                sel_next     = 1'b1;
                anc_col_next = cur_col_reg;
                anc_row_next = cur_row_reg;
            end
        end else if (sel_reg) begin
            mask_new[ST_UNDO]    = 1'b1;
            mask_new[ST_REF_SEL] = 1'b1;
            sel_next             = 1'b0;
        end
        mask_new[ST_PASTE] = !pkt.right && rheld_reg;
        rheld_next         = pkt.right;
        if (!nc[10] && (nc[9:8] == 2'b00) && (nc[7:0] < screen_columns)) begin
            cur_col_next = nc[7:0];
        end
        if (!nr[10] && (nr[9:8] == 2'b00) && (nr[7:0] < screen_rows)) begin
            cur_row_next = nr[7:0];
        end
        mask_next = emit ? mask_left : mask_reg;
        if (pkt_pop) begin
            mask_next = mask_new;
        end
    end

    // command of the lowest pending slot
    always_comb begin
        out_cmd  = CMD_REFRESH;
        out_rect = '0;
        if (low_bit[ST_UNDO]) begin
            out_cmd  = CMD_UNDO_SEL;
            out_rect = undo_rect_reg;
        end else if (low_bit[ST_DRAW_SEL]) begin
            out_cmd  = CMD_DRAW_SEL;
            out_rect = draw_rect_reg;
        end else if (low_bit[ST_PASTE]) begin
            out_cmd  = CMD_PASTE;
        end else if (low_bit[ST_ERASE]) begin
            out_cmd  = CMD_ERASE_CUR;
            out_rect = '{row_start: old_row_reg, col_start: old_col_reg,
                         row_end: 8'd0, col_end: 8'd0};
        end else if (low_bit[ST_DRAW_CUR]) begin
            out_cmd  = CMD_DRAW_CUR;
            out_rect = '{row_start: new_row_reg, col_start: new_col_reg,
                         row_end: 8'd0, col_end: 8'd0};
        end
        out_valid_next = emit ? 1'b1 : (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg       <= 1'b0;
            rheld_reg     <= 1'b0;
            cur_col_reg   <= RESET_CURSOR;
            cur_row_reg   <= RESET_CURSOR;
            anc_col_reg   <= '0;
            anc_row_reg   <= '0;
            end_col_reg   <= '0;
            end_row_reg   <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pkt_pop) begin
                sel_reg     <= sel_next;
                rheld_reg   <= rheld_next;
                cur_col_reg <= cur_col_next;
                cur_row_reg <= cur_row_next;
                anc_col_reg <= anc_col_next;
                anc_row_reg <= anc_row_next;
                end_col_reg <= end_col_next;
                end_row_reg <= end_row_next;
            end
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pkt_pop) begin
            undo_rect_reg <= undo_rect_next;
            draw_rect_reg <= draw_rect_next;
            old_col_reg   <= cur_col_reg;
            old_row_reg   <= cur_row_reg;
            new_col_reg   <= cur_col_next;
            new_row_reg   <= cur_row_next;
        end
        if (emit) begin
            out_cmd_reg  <= out_cmd;
            out_rect_reg <= out_rect;
            out_last_reg <= (mask_left == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'b00000, out_rect_reg.col_end, out_rect_reg.row_end,
                       out_rect_reg.col_start, out_rect_reg.row_start, out_cmd_reg};

endmodule

// ----- src/mouse_packet_cursor_selection.sv -----
// A packet passes the packet queue, the command sequencer and its registered output stage in turn.
// Throughput: one command per cycle while m_tready is high; a packet yields 3 to 6 commands,
// set by the command sequencer; bytes are taken every cycle while the packet queue has room.
// Reset: synchronous, active low; cursor at (10,10), 80 columns, 25 rows, no selection.
// ----------------------------------------------------------------------------
// mouse_packet_cursor_selection
// Mouse packet decoder driving a text cursor, drag selection and paste requests.
// ----------------------------------------------------------------------------
module mouse_packet_cursor_selection #(
    parameter int SPEED_DIVISOR = 10,
    parameter int QUEUE_DEPTH   = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] from_aux
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [2:0] command, [10:3] row_start, [18:11] col_start,
                                   // [26:19] row_end, [34:27] col_end, [39:35] zero
    output logic        m_tlast,   // [0] last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import mpcs_pkg::*;

    logic [7:0]   cols_reg, rows_reg;
    logic         push, pop;
    packet_t      push_pkt, pop_pkt;
    fifo_status_t q_status;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_status.full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= RESET_COLUMNS;
            rows_reg <= RESET_ROWS;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_COLUMNS: cols_reg <= cfg_data;
                CFG_ROWS:    rows_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    mpcs_front #(
        .SPEED_DIVISOR(SPEED_DIVISOR)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_accept(s_tvalid && s_tready),
        .data_byte  (s_tdata),
        .from_aux   (s_tuser),
        .push       (push),
        .push_pkt   (push_pkt)
    );

    mpcs_fifo #(
        .WIDTH($bits(packet_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_pkt),
        .pop      (pop),
        .pop_data (pop_pkt),
        .status   (q_status)
    );

    mpcs_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .screen_columns(cols_reg),
        .screen_rows   (rows_reg),
        .pkt_valid     (q_status.valid),
        .pkt           (pop_pkt),
        .pkt_pop       (pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast)
    );

endmodule

// ----- src/mpcs_checker.sv -----
// ----------------------------------------------------------------------------
// mpcs_checker
// Port-level checks on the command stream of the cursor selection block.
// ----------------------------------------------------------------------------
module mpcs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);
    import mpcs_pkg::*;

    logic [2:0] cmd;
    assign cmd = m_tdata[2:0];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output transaction changed while stalled");

    a_last_is_refresh: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> cmd == CMD_REFRESH)
        else $error("packet run does not end in refresh");

    a_cursor_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (cmd == CMD_ERASE_CUR || cmd == CMD_DRAW_CUR) |-> m_tdata[39:19] == '0)
        else $error("cursor command carries end corner");

    a_plain_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (cmd == CMD_REFRESH || cmd == CMD_PASTE) |-> m_tdata[39:3] == '0)
        else $error("refresh or paste carries coordinates");

    a_draw_then_refresh: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && cmd == CMD_DRAW_CUR |=> m_tvalid && cmd == CMD_REFRESH && m_tlast)
        else $error("cursor draw not followed by final refresh");

endmodule

bind mouse_packet_cursor_selection mpcs_checker u_mpcs_checker (.*);
